// ----- rtl/mfa_pkg.sv -----
`timescale 1ns / 1ps
package mfa_pkg;
    localparam int OPERAND_BITS = 16;
    localparam int OPW = 16;
    localparam int PW = 2 * OPW;
    localparam int WW = 64;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_DIV = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic signed [OPW-1:0] a_whole;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_whole;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [WW-1:0] r_whole;
        logic signed [WW-1:0] r_num;
        logic signed [WW-1:0] r_den;
        logic                 div_zero;
    } t_out;

    // classified job handed from front to back
    typedef struct packed {
        logic          bypass;   // result already known (error or unused code)
        logic          err;
        logic [WW-1:0] whole;
        logic [WW-1:0] num;
        logic [WW-1:0] den;
    } t_job;

    function automatic logic [WW-1:0] sext(input logic [OPW-1:0] v);
        logic [WW-1:0] x;
        x = {{(WW-OPERAND_BITS){v[OPERAND_BITS-1]}}, v[OPERAND_BITS-1:0]};
        return x;
    endfunction
endpackage

// ----- rtl/mfa_front.sv -----
`timescale 1ns / 1ps
module mfa_front import mfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_in   i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_job  o_job
);
    // p1: operand products, p2: improper numerators, p3: final products and job
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_P1   = 3'd1;
    localparam logic [2:0] S_P2   = 3'd2;
    localparam logic [2:0] S_P3   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [1:0]            r_cmd;
    logic signed [OPW-1:0] r_aw, r_an, r_ad, r_bw, r_bn, r_bd;
    logic signed [PW-1:0]  r_x, r_y, r_z;
    logic signed [PW-1:0]  r_ai, r_bi;
    t_job                  r_job, n_job;
    logic signed [WW-1:0]  p_mul, p_div_num, p_div_den;

    assign o_full  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_job   = r_job;
    assign p_mul     = r_ai * r_bi;
    assign p_div_num = r_ai * r_bd;
    assign p_div_den = r_ad * r_bi;

    always_comb begin
        n_state = r_state;
        n_job = r_job;
        case (r_state)
            S_IDLE: if (i_push) n_state = S_P1;
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: begin
                n_state = S_OUT;
                n_job = '0;
                case (r_cmd)
                    CMD_ADD: begin
                        if (r_z == '0) begin
                            n_job.bypass = 1'b1;
                            n_job.err = 1'b1;
                        end else begin
                            n_job.whole = sext(r_aw) + sext(r_bw);
                            n_job.num = WW'(r_x) + WW'(r_y);
                            n_job.den = WW'(r_z);
                        end
                    end
                    CMD_MUL: begin
                        n_job.num = p_mul;
                        n_job.den = (r_z == '0) ? WW'(1) : WW'(r_z);
                    end
                    CMD_DIV: begin
                        n_job.num = p_div_num;
                        n_job.den = (p_div_den == '0) ? WW'(1) : p_div_den;
                    end
                    default: n_job.bypass = 1'b1;
                endcase
            end
            S_OUT: if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && i_push) begin
            r_cmd <= i_item.cmd;
            r_aw <= OPW'(sext(i_item.a_whole));
            r_an <= OPW'(sext(i_item.a_num));
            r_ad <= OPW'(sext(i_item.a_den));
            r_bw <= OPW'(sext(i_item.b_whole));
            r_bn <= OPW'(sext(i_item.b_num));
            r_bd <= OPW'(sext(i_item.b_den));
        end
        if (r_state == S_P1) begin
            // add: x=an*bd y=bn*ad z=ad*bd; mul/div: x=aw*ad y=bw*bd
            if (r_cmd == CMD_ADD) begin
                r_x <= r_an * r_bd;
                r_y <= r_bn * r_ad;
            end else begin
                r_x <= r_aw * r_ad;
                r_y <= r_bw * r_bd;
            end
            r_z <= r_ad * r_bd;
        end
        if (r_state == S_P2) begin
            r_ai <= r_x + PW'(r_an);
            r_bi <= r_y + PW'(r_bn);
        end
        if (r_state == S_P3) r_job <= n_job;
    end
endmodule

// ----- rtl/mfa_fifo.sv -----
`timescale 1ns / 1ps
module mfa_fifo import mfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_job o_job
);
    // two-entry queue
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
        if (i_wr) r_mem[r_wp] <= i_job;
    end
endmodule

// ----- rtl/mfa_divider.sv -----
`timescale 1ns / 1ps
module mfa_divider import mfa_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic          o_done,
    output logic [WW-1:0] o_q,
    output logic [WW-1:0] o_r
);
    // restoring divide on magnitudes, one bit a cycle, C truncation semantics
    logic          r_busy, r_done;
    logic [6:0]    r_cnt;
    logic [WW-1:0] r_q, r_rem, r_d, r_a0, r_b0;
    logic [WW:0]   trial;
    logic [WW-1:0] sh;
    logic          qn, rn;

    assign sh    = {r_rem[WW-2:0], r_q[WW-1]};
    assign trial = {1'b0, sh} - {1'b0, r_d};
    assign o_done = r_done;
    assign qn = r_a0[WW-1] ^ r_b0[WW-1];
    assign rn = r_a0[WW-1];
    assign o_q = (r_b0 == '0) ? '0 : (qn ? -r_q : r_q);
    assign o_r = (r_b0 == '0) ? r_a0 : (rn ? -r_rem : r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_a0 <= i_a;
            r_b0 <= i_b;
            r_q <= i_a[WW-1] ? -i_a : i_a;
            r_d <= i_b[WW-1] ? -i_b : i_b;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (!trial[WW] && r_rem[WW-1] == 1'b0) begin
                r_rem <= trial[WW-1:0];
                r_q <= {r_q[WW-2:0], 1'b1};
            end else if (r_rem[WW-1]) begin
                r_rem <= sh - r_d;
                r_q <= {r_q[WW-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q <= {r_q[WW-2:0], 1'b0};
            end
        end
    end
endmodule

// ----- rtl/mfa_back.sv -----
`timescale 1ns / 1ps
module mfa_back import mfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_take,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_res
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SPLIT = 3'd1;
    localparam logic [2:0] S_GCD = 3'd2;
    localparam logic [2:0] S_DNUM = 3'd3;
    localparam logic [2:0] S_DDEN = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [WW-1:0] r_whole, n_whole, r_num, n_num, r_den, n_den, r_less, n_less;
    logic [WW-1:0] r_dva, n_dva, r_dvb, n_dvb;
    logic          r_start, n_start;
    t_out          r_res, n_res;
    logic          r_full, n_full;
    logic          dv_done;
    logic [WW-1:0] dv_q, dv_r;

    mfa_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_a(r_dva), .i_b(r_dvb), .o_done(dv_done), .o_q(dv_q), .o_r(dv_r)
    );

    assign o_take  = (r_state == S_IDLE) && i_valid && !r_full;
    assign o_empty = !r_full;
    assign o_res   = r_res;

    always_comb begin
        n_state = r_state;
        n_whole = r_whole;
        n_num = r_num;
        n_den = r_den;
        n_less = r_less;
        n_dva = r_dva;
        n_dvb = r_dvb;
        n_start = 1'b0;
        n_res = r_res;
        n_full = r_full && !i_pop;
        case (r_state)
            S_IDLE: if (o_take) begin
                if (i_job.bypass) begin
                    n_res = '0;
                    n_res.div_zero = i_job.err;
                    n_full = 1'b1;
                end else begin
                    n_whole = i_job.whole;
                    n_den = i_job.den;
                    n_dva = i_job.num;
                    n_dvb = i_job.den;
                    n_start = 1'b1;
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: if (dv_done) begin
                // proper form, then euclid starts on (remainder, den)
                n_whole = r_whole + dv_q;
                n_num = dv_r;
                n_less = r_den;
                n_dva = dv_r;
                n_dvb = r_den;
                n_start = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: if (dv_done) begin
                if (dv_r != '0) begin
                    n_less = dv_r;
                    n_dva = r_less;
                    n_dvb = dv_r;
                end else begin
                    // last nonzero remainder is the gcd, sign included
                    n_dva = r_num;
                    n_dvb = r_less;
                    n_state = S_DNUM;
                end
                n_start = 1'b1;
            end
            S_DNUM: if (dv_done) begin
                n_num = dv_q;
                n_dva = r_den;
                n_dvb = r_less;
                n_start = 1'b1;
                n_state = S_DDEN;
            end
            S_DDEN: if (dv_done) begin
                n_den = dv_q;
                n_state = S_OUT;
            end
            S_OUT: if (!r_full || i_pop) begin
                n_res.r_whole = r_whole;
                n_res.r_num = r_num;
                n_res.r_den = r_den;
                n_res.div_zero = 1'b0;
                n_full = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full <= n_full;
            r_start <= n_start;
        end
        r_whole <= n_whole;
        r_num <= n_num;
        r_den <= n_den;
        r_less <= n_less;
        r_dva <= n_dva;
        r_dvb <= n_dvb;
        r_res <= n_res;
    end
endmodule

// ----- rtl/mixed_fraction_alu_core.sv -----
`timescale 1ns / 1ps
// channel  | ports              | transfer when
// input    | i_push o_full i_in | i_push & !o_full
// result   | o_empty i_pop o_out| i_pop & !o_empty
// the front holds an item (o_full high) through states P1, P2, P3 and OUT until
// it enters the 2-deep queue, from which the back takes it when idle; the back
// then runs divider passes: one split, one per euclid remainder step, two for
// the reduction, and then loads the result register.
// the 64-bit bit-serial divider sets the rate. reset is synchronous and
// clears all control; front and back stall independently around the queue.
module mixed_fraction_alu_core import mfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_in  i_in,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_out
);
    logic f_valid, q_full, q_valid, b_take;
    t_job f_job, q_job;

    mfa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_item(i_in), .o_valid(f_valid), .i_take(f_valid && !q_full), .o_job(f_job)
    );
    mfa_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(f_valid && !q_full), .i_job(f_job),
        .o_full(q_full), .i_rd(b_take), .o_valid(q_valid), .o_job(q_job)
    );
    mfa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_job(q_job),
        .o_take(b_take), .o_empty(o_empty), .i_pop(i_pop), .o_res(o_out)
    );
endmodule
